// ===== sv/stable_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core_defines.svh
// Assertion macros shared by the priority queue modules.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OCC_W         = 5;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] data_in;
    logic signed [31:0] priority_req;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic               data_valid;
    logic               was_empty;
    logic               dropped_full;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    RES_INSERT,
    RES_DROP,
    RES_POP,
    RES_EMPTY
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      rd_pos;
    logic      rd_head;
    logic      wr_shift;
    logic      wr_new;
    logic      pop;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode;
    logic full;
    logic empty;
    logic pos_zero;
    logic rd_ge;
    logic out_free;
  } status_t;

endpackage

// ===== sv/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert (tail-to-head shift walk) and dequeue transactions.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_core_defines.svh"

module spq_ctrl import spq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CMP,
    S_DEQ_DATA,
    S_FIN
  } state_t;

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    state_next   = state;
    kind_next    = kind;
    req_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.mode == MODE_INSERT) begin
          priority if (st.full) begin
            kind_next  = RES_DROP;
            state_next = S_FIN;
          end else if (st.pos_zero) begin
            cmd.wr_new = 1'b1;
            kind_next  = RES_INSERT;
            state_next = S_FIN;
          end else begin
            cmd.rd_pos = 1'b1;
            state_next = S_INS_CMP;
          end
        end else begin
          if (st.empty) begin
            kind_next  = RES_EMPTY;
            state_next = S_FIN;
          end else begin
            cmd.rd_head = 1'b1;
            state_next  = S_DEQ_DATA;
          end
        end
      end
      S_INS_CMP: begin
        // stop behind any entry of equal or higher priority
        if (st.rd_ge) begin
          cmd.wr_new = 1'b1;
          kind_next  = RES_INSERT;
          state_next = S_FIN;
        end else begin
          cmd.wr_shift = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DEQ_DATA: begin
        cmd.pop    = 1'b1;
        kind_next  = RES_POP;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_INSERT;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  `SPQ_ASSERT_NEXT(a_accept_starts, clk, rst, req_valid && req_ready, state == S_DECIDE, "accepted transaction did not start")
  `SPQ_ASSERT(a_res_slot_free, clk, rst, !cmd.res_load || st.out_free, "result loaded over a waiting result")
  `SPQ_ASSERT_NEXT(a_res_to_idle, clk, rst, cmd.res_load, state == S_IDLE, "sequencer not idle after result")

endmodule

// ===== sv/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Circular sorted entry store, head/count/position registers, result register.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_core_defines.svh"

module spq_datapath import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t st,
  output rsp_t    rsp,
  output logic    rsp_valid,
  input  logic    rsp_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          item;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [AW-1:0] head;
  logic [CW-1:0] pos_m1;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [CW+OCC_W-1:0] count_ext;

  // logical slot (0 = head) to physical RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, l};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign pos_m1 = pos - CW'(1);

  assign re    = cmd.rd_pos || cmd.rd_head;
  assign raddr = cmd.rd_head ? head : phys(head, pos_m1[AW-1:0]);
  assign we    = cmd.wr_shift || cmd.wr_new;
  assign waddr = phys(head, pos[AW-1:0]);

  always_comb begin
    if (cmd.wr_new) begin
      wdata.data = item.data_in;
      wdata.prio = item.priority_req;
    end else begin
      wdata = rdata;
    end
  end

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st.mode     = item.mode;
  assign st.full     = (count == CW'(DEPTH));
  assign st.empty    = (count == '0);
  assign st.pos_zero = (pos == '0);
  assign st.rd_ge    = (rdata.prio >= item.priority_req);
  assign st.out_free = !rsp_valid || rsp_ready;

  assign count_ext = {{OCC_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
      pos  <= count;
    end else if (cmd.wr_shift) begin
      pos <= pos_m1;
    end
    if (cmd.res_load) begin
      // head data is still on the read port for a dequeue
      rsp.data_out     <= (cmd.res_kind == RES_POP) ? rdata.data : '0;
      rsp.data_valid   <= (cmd.res_kind == RES_POP);
      rsp.was_empty    <= (cmd.res_kind == RES_EMPTY);
      rsp.dropped_full <= (cmd.res_kind == RES_DROP);
      rsp.occupancy    <= count_ext[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
        head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `SPQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_no_write_full, clk, rst, !cmd.wr_new || !st.full, "insert written into full store")
  `SPQ_ASSERT_NEXT(a_pop_count, clk, rst, cmd.pop, count == $past(count) - CW'(1), "dequeue did not drop count")

endmodule

// ===== sv/stable_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue, highest priority first, equal priorities in FIFO order.
// ----------------------------------------------------------------------------
// Holds up to DEPTH entries (32-bit data, 32-bit signed priority) sorted in
// descending priority in a circular RAM. Each req transaction (mode 0 insert,
// mode 1 dequeue) yields exactly one rsp transaction. A dequeue does one RAM
// read of the head slot, then the head pointer advances. An insert walks
// from the tail towards the head, one step per stored entry of strictly lower
// priority, and each step is one RAM read plus one write through the single
// registered read port, moving an entry down one slot; the new entry is then
// written behind the first entry of equal or higher priority, or at the head.
// A new transaction is accepted only while the sequencer is idle; a finished
// result sits in the output register, so the next request can be taken while
// the previous result still waits for rsp_ready, and a later result waits in
// the sequencer until that register is free. Insert into a full queue is
// refused (dropped_full), dequeue from an empty queue flags was_empty;
// occupancy is the entry count after the transaction, low 5 bits. The RAM
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  // response channel
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t st;

  // sequencer: decides each step of the shift walk or dequeue
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // storage, pointers, compare and result register
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
